>>> hw/rtl/tmcs_pkg.sv
// Shared types and constants for the trimmed mean channel scanner.
`default_nettype none
package tmcs_pkg;

	localparam int SAMPLE_W   = 12;
	localparam int CHAN_W     = 5;
	localparam int SLOT_W     = 2;
	localparam int CFG_IDX_W  = 2;
	localparam int SAMPLE_MAX = 4095;

	typedef logic [SAMPLE_W-1:0]  sample_t;
	typedef logic [CHAN_W-1:0]    chan_t;
	typedef logic [SLOT_W-1:0]    slot_t;
	typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

	// Slot codes; the scan runs 0, 1, 2 and wraps.
	localparam slot_t SLOT_0    = 2'd0;
	localparam slot_t SLOT_1    = 2'd1;
	localparam slot_t SLOT_2    = 2'd2;
	localparam slot_t SLOT_LAST = SLOT_2;

	// Configuration register indexes.
	localparam cfg_idx_t REG_CHAN_SLOT0 = 2'd0;
	localparam cfg_idx_t REG_CHAN_SLOT1 = 2'd1;
	localparam cfg_idx_t REG_CHAN_SLOT2 = 2'd2;

	// Channel assignments after reset.
	localparam chan_t CHAN_SLOT0_RST = 5'd1;
	localparam chan_t CHAN_SLOT1_RST = 5'd4;
	localparam chan_t CHAN_SLOT2_RST = 5'd5;

	// Window status from the accumulator for the sample being stepped.
	typedef struct packed {
		logic    last;
		sample_t average;
	} tmcs_win_t;

endpackage : tmcs_pkg
`default_nettype wire

>>> hw/rtl/tmcs_accum.sv
// Window accumulator: settle count, running extremes, running sum and trimmed mean.
`default_nettype none
module tmcs_accum #(
	parameter int SETTLE      = 2,
	parameter int WINDOW_LOG2 = 4
) (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  step,
	input  tmcs_pkg::sample_t    sample,
	output tmcs_pkg::tmcs_win_t  win
);
	import tmcs_pkg::*;

	localparam int LAST_COUNT = SETTLE + (2 ** WINDOW_LOG2) + 2;
	localparam int CNT_W      = $clog2(LAST_COUNT + 1);
	localparam int SUM_W      = $clog2(((2 ** WINDOW_LOG2) + 2) * SAMPLE_MAX + 1);

	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] count_inc;
	sample_t          max_q;
	sample_t          min_q;
	logic [SUM_W-1:0] sum_q;

	logic             settling;
	sample_t          max_new;
	sample_t          min_new;
	logic [SUM_W-1:0] sum_new;
	logic [SUM_W-1:0] trimmed;

	always_comb begin
		count_inc = count_q + CNT_W'(1);
		settling  = (count_inc <= CNT_W'(SETTLE));
		max_new   = (sample > max_q) ? sample : max_q;
		min_new   = (sample < min_q) ? sample : min_q;
		sum_new   = sum_q + SUM_W'(sample);
		trimmed   = sum_new - SUM_W'(min_new) - SUM_W'(max_new);
		win.last    = !settling && (count_inc == CNT_W'(LAST_COUNT));
		win.average = trimmed[WINDOW_LOG2 +: SAMPLE_W];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			max_q   <= '0;
			min_q   <= SAMPLE_W'(SAMPLE_MAX);
			sum_q   <= '0;
		end else if (step) begin
			if (win.last) begin
				count_q <= '0;
				max_q   <= '0;
				min_q   <= SAMPLE_W'(SAMPLE_MAX);
				sum_q   <= '0;
			end else if (settling) begin
				count_q <= count_inc;
			end else begin
				count_q <= count_inc;
				max_q   <= max_new;
				min_q   <= min_new;
				sum_q   <= sum_new;
			end
		end
	end

endmodule : tmcs_accum
`default_nettype wire

>>> hw/rtl/trimmed_mean_channel_scan_core.sv
// Trimmed mean channel scanner top level: handshakes, slot sequencing, config and result register.
// A closing request is held in the input stage; its result then loads into the output register.
// Throughput: one sample request per cycle, sustained; one result per SETTLE + 2**WINDOW_LOG2 + 2
// samples. The input is held back only when a finished result is still waiting in the output
// register and the staged sample would close another window.
// Reset (arst_n low, asynchronous): window cleared, slot 0, channel registers 1, 4 and 5.
`default_nettype none
module trimmed_mean_channel_scan_core #(
	parameter int SETTLE      = 2,
	parameter int WINDOW_LOG2 = 4
) (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  in_valid,
	output logic                 in_ready,
	input  tmcs_pkg::sample_t    sample,
	output logic                 out_valid,
	input  wire                  out_ready,
	output tmcs_pkg::slot_t      slot,
	output tmcs_pkg::sample_t    average,
	output tmcs_pkg::chan_t      next_channel,
	input  wire                  cfg_wen,
	input  tmcs_pkg::cfg_idx_t   cfg_index,
	input  tmcs_pkg::chan_t      cfg_data
);
	import tmcs_pkg::*;

	// Input stage: one sample request is registered here before it reaches the accumulator.
	logic      valid_s1;
	sample_t   sample_s1;

	// Scan state and channel registers.
	slot_t     slot_q;
	slot_t     slot_next;
	chan_t     chan0_q;
	chan_t     chan1_q;
	chan_t     chan2_q;
	chan_t     chan_next;

	// Output register.
	logic      out_valid_q;
	slot_t     out_slot_q;
	sample_t   average_q;
	chan_t     next_channel_q;

	tmcs_win_t win;
	logic      out_free;
	logic      s1_advance;
	logic      result_load;

	// The staged sample moves on unless it closes a window while the previous
	// result has not yet been taken; samples inside a window never wait.
	assign out_free    = !out_valid_q || out_ready;
	assign s1_advance  = valid_s1 && (!win.last || out_free);
	assign result_load = s1_advance && win.last;
	assign in_ready    = !valid_s1 || s1_advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			sample_s1 <= sample;
		end
	end

	tmcs_accum #(
		.SETTLE      (SETTLE),
		.WINDOW_LOG2 (WINDOW_LOG2)
	) u_accum (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (s1_advance),
		.sample (sample_s1),
		.win    (win)
	);

	// The slot wraps after the last one; the channel sent out with a result is
	// the one programmed for the slot that comes next.
	always_comb begin
		slot_next = (slot_q == SLOT_LAST) ? SLOT_0 : slot_q + SLOT_W'(1);
		case (slot_next)
			SLOT_0:  chan_next = chan0_q;
			SLOT_1:  chan_next = chan1_q;
			SLOT_2:  chan_next = chan2_q;
			default: chan_next = chan0_q;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_q <= SLOT_0;
		end else if (result_load) begin
			slot_q <= slot_next;
		end
	end

	// Channel registers. A write to an index past the list is dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chan0_q <= CHAN_SLOT0_RST;
			chan1_q <= CHAN_SLOT1_RST;
			chan2_q <= CHAN_SLOT2_RST;
		end else if (cfg_wen) begin
			case (cfg_index)
				REG_CHAN_SLOT0: chan0_q <= cfg_data;
				REG_CHAN_SLOT1: chan1_q <= cfg_data;
				REG_CHAN_SLOT2: chan2_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Output register: loaded when a window closes, released when taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (result_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (result_load) begin
			out_slot_q     <= slot_q;
			average_q      <= win.average;
			next_channel_q <= chan_next;
		end
	end

	assign out_valid    = out_valid_q;
	assign slot         = out_slot_q;
	assign average      = average_q;
	assign next_channel = next_channel_q;

	// A new result only ever appears straight after a window-closing step.
	a_result_follows_step: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(result_load))
		else $error("result appeared without a closing sample");

	// The slot changes only together with a result being produced.
	a_slot_moves_with_result: assert property (@(posedge clk) disable iff (!arst_n)
		(slot_q != $past(slot_q)) |-> $past(result_load))
		else $error("slot advanced without a result");

	// A closing sample must not overwrite a result that is still waiting.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_ready && valid_s1 && win.last) |-> (!in_ready && !s1_advance))
		else $error("pending result would be overwritten");

	// The slot never leaves the three-slot scan.
	a_slot_range: assert property (@(posedge clk) disable iff (!arst_n)
		(slot_q <= SLOT_LAST))
		else $error("slot out of range");

endmodule : trimmed_mean_channel_scan_core
`default_nettype wire
